[hw/rtl/crm_pkg.sv]
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types and constants for the camera readout monitor: item and result
// payloads, monitor mode encoding, event codes and register map.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // request kinds carried in the func field
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_START   = 2'd1;
    localparam logic [1:0] FUNC_STOP    = 2'd2;
    localparam logic [1:0] FUNC_TRIGGER = 2'd3;

    // event codes
    localparam logic [2:0] EV_IDLE     = 3'd0;
    localparam logic [2:0] EV_WAITING  = 3'd1;
    localparam logic [2:0] EV_ALIGN    = 3'd2;
    localparam logic [2:0] EV_READOUT  = 3'd3;
    localparam logic [2:0] EV_EXPOSING = 3'd4;

    // monitor state codes as reported
    localparam logic [1:0] MS_IDLE  = 2'd0;
    localparam logic [1:0] MS_START = 2'd1;
    localparam logic [1:0] MS_ACQ   = 2'd2;
    localparam logic [1:0] MS_STOP  = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_STARTUP  = 3'd1;
    localparam logic [2:0] REG_READOUT  = 3'd2;
    localparam logic [2:0] REG_SHUTDOWN = 3'd3;
    localparam logic [2:0] REG_PULSE    = 3'd4;
    localparam logic [2:0] REG_SUPPRESS = 3'd5;

    // register reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd5;
    localparam logic [15:0] STARTUP_RST  = 16'hFFFF;
    localparam logic [15:0] READOUT_RST  = 16'h7A11;
    localparam logic [15:0] SHUTDOWN_RST = 16'h2625;
    localparam logic [7:0]  PULSE_RST    = 8'd5;
    localparam logic [15:0] SUPPRESS_RST = 16'd500;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_START = 4'b0010,
        MODE_ACQ   = 4'b0100,
        MODE_STOP  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        camera_line;
        logic        line_watch;
        logic        highres_mode;
        logic [15:0] exposure_ms;
    } item_t;

    typedef struct packed {
        logic       trigger_out;
        logic       event_valid;
        logic [2:0] event_code;
        logic       stop_flag;
        logic       busy_status;
        logic [1:0] monitor_state;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        c = MS_IDLE;
        case (m)
            MODE_IDLE:  c = MS_IDLE;
            MODE_START: c = MS_START;
            MODE_ACQ:   c = MS_ACQ;
            MODE_STOP:  c = MS_STOP;
            default:    c = MS_IDLE;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/camera_readout_monitor_top.sv]
// ----------------------------------------------------------------------------
// camera_readout_monitor_top
// Camera acquisition monitor: debounces the camera busy line or simulates
// camera delays, tracks the acquisition mode and drives the trigger pulse.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+------------------
//   item     | in        | item_valid / item_ready     | crm_pkg::item_t
//   result   | out       | result_valid / result_ready | crm_pkg::result_t
//   apb      | in/out    | psel, penable, pready       | paddr, pwdata, prdata
//
// One item per cycle while item_ready is high: an item's state update and
// result are decided in its transfer cycle and go to a two-entry result queue.
// item_ready is low only while both queue entries hold untaken results.
// rst_n clears the monitor state, the queue and loads register defaults.
// A stalled result stays at the head of the queue unchanged.
// ----------------------------------------------------------------------------
module camera_readout_monitor_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  crm_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output crm_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crm_pkg::ADDR_W-1:0] paddr,
    input  logic [crm_pkg::DATA_W-1:0] pwdata,
    output logic [crm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import crm_pkg::*;

    // configuration
    logic [15:0] debounce_reg, startup_reg, readout_reg, shutdown_reg, suppress_reg;
    logic [7:0]  pulse_ticks_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RST;
            startup_reg     <= STARTUP_RST;
            readout_reg     <= READOUT_RST;
            shutdown_reg    <= SHUTDOWN_RST;
            pulse_ticks_reg <= PULSE_RST;
            suppress_reg    <= SUPPRESS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DEBOUNCE: debounce_reg    <= pwdata[15:0];
                REG_STARTUP:  startup_reg     <= pwdata[15:0];
                REG_READOUT:  readout_reg     <= pwdata[15:0];
                REG_SHUTDOWN: shutdown_reg    <= pwdata[15:0];
                REG_PULSE:    pulse_ticks_reg <= pwdata[7:0];
                REG_SUPPRESS: suppress_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            REG_STARTUP:  prdata = {16'd0, startup_reg};
            REG_READOUT:  prdata = {16'd0, readout_reg};
            REG_SHUTDOWN: prdata = {16'd0, shutdown_reg};
            REG_PULSE:    prdata = {24'd0, pulse_ticks_reg};
            REG_SUPPRESS: prdata = {16'd0, suppress_reg};
            default:      prdata = '0;
        endcase
    end

    // monitor state
    mode_t       mode_reg, mode_next;
    logic        busy_reg, busy_next;
    logic        watch_reg, watch_next;
    logic [15:0] delay_reg, delay_next;
    logic        running_reg, running_next;
    logic [7:0]  pulse_cnt_reg, pulse_cnt_next;
    logic        pulse_lvl_reg, pulse_lvl_next;
    result_t     res;

    logic [1:0]  q_cnt_reg, q_cnt_next;
    result_t     q0_reg, q0_next, q1_reg, q1_next;
    logic        push, pop;

    assign item_ready   = (q_cnt_reg != 2'd2);
    assign result_valid = (q_cnt_reg != 2'd0);
    assign result       = q0_reg;
    assign push         = item_valid && item_ready;
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        logic       supp;
        logic       tgt;
        logic [7:0] pc;

        mode_next      = mode_reg;
        busy_next      = busy_reg;
        watch_next     = watch_reg;
        delay_next     = delay_reg;
        running_next   = running_reg;
        pulse_cnt_next = pulse_cnt_reg;
        pulse_lvl_next = pulse_lvl_reg;
        res            = '0;
        supp = item.highres_mode && (item.exposure_ms < suppress_reg);
        tgt  = watch_reg && item.camera_line;
        pc   = pulse_cnt_reg + 8'd1;

        case (item.func)
            FUNC_TICK:
            begin
                // advance the trigger pulse
                if (pulse_lvl_reg)
                begin
                    if (pc >= pulse_ticks_reg || pc == 8'd0)
                    begin
                        pulse_lvl_next = 1'b0;
                        pulse_cnt_next = 8'd0;
                    end
                    else
                        pulse_cnt_next = pc;
                end
                // run the countdown, commit status on expiry
                if (running_reg)
                begin
                    if (delay_reg <= 16'd1)
                    begin
                        running_next = 1'b0;
                        delay_next   = 16'd0;
                        if (tgt != busy_reg)
                        begin
                            busy_next = tgt;
                            case (mode_reg)
                                MODE_START:
                                begin
                                    mode_next       = MODE_ACQ;
                                    res.event_valid = 1'b1;
                                    res.event_code  = EV_ALIGN;
                                end
                                MODE_ACQ:
                                begin
                                    if (!supp)
                                    begin
                                        res.event_valid = 1'b1;
                                        res.event_code  = tgt ? EV_READOUT : EV_EXPOSING;
                                    end
                                end
                                MODE_STOP:
                                begin
                                    res.stop_flag   = 1'b1;
                                    res.event_valid = 1'b1;
                                    res.event_code  = EV_IDLE;
                                end
                                default: ;
                            endcase
                        end
                    end
                    else
                        delay_next = delay_reg - 16'd1;
                end
                // sample the line: start or shorten the debounce
                if (watch_reg && item.camera_line != busy_next)
                begin
                    if (!running_next)
                    begin
                        delay_next   = debounce_reg;
                        running_next = 1'b1;
                    end
                    else if (delay_next > debounce_reg)
                        delay_next = debounce_reg;
                end
            end
            FUNC_START:
            begin
                watch_next      = item.line_watch;
                mode_next       = MODE_START;
                res.event_valid = 1'b1;
                res.event_code  = EV_WAITING;
                if (!item.line_watch)
                begin
                    busy_next    = 1'b1;
                    delay_next   = startup_reg;
                    running_next = 1'b1;
                end
            end
            FUNC_STOP:
            begin
                res.event_valid = 1'b1;
                if (!busy_reg)
                begin
                    mode_next      = MODE_IDLE;
                    res.stop_flag  = 1'b1;
                    res.event_code = EV_IDLE;
                end
                else
                begin
                    mode_next      = MODE_STOP;
                    res.event_code = EV_WAITING;
                    if (!watch_reg)
                    begin
                        busy_next    = 1'b1;
                        delay_next   = shutdown_reg;
                        running_next = 1'b1;
                    end
                end
            end
            default:
            begin
                // readout trigger: restart the pulse
                pulse_lvl_next = 1'b1;
                pulse_cnt_next = 8'd0;
                if (!supp && !watch_reg)
                begin
                    res.event_valid = 1'b1;
                    res.event_code  = EV_READOUT;
                    busy_next       = 1'b1;
                    delay_next      = readout_reg;
                    running_next    = 1'b1;
                end
            end
        endcase

        res.trigger_out   = pulse_lvl_next;
        res.busy_status   = busy_next;
        res.monitor_state = mode_code(mode_next);
    end

    // result queue
    always_comb
    begin
        logic [1:0] left;

        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q_cnt_next = q_cnt_reg;
        left       = q_cnt_reg - {1'b0, pop};

        if (pop)
            q0_next = q1_reg;
        if (push)
        begin
            if (left == 2'd0)
                q0_next = res;
            else
                q1_next = res;
        end
        q_cnt_next = left + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            busy_reg      <= 1'b0;
            watch_reg     <= 1'b1;
            delay_reg     <= 16'd0;
            running_reg   <= 1'b0;
            pulse_cnt_reg <= 8'd0;
            pulse_lvl_reg <= 1'b0;
            q_cnt_reg     <= 2'd0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (push)
            begin
                mode_reg      <= mode_next;
                busy_reg      <= busy_next;
                watch_reg     <= watch_next;
                delay_reg     <= delay_next;
                running_reg   <= running_next;
                pulse_cnt_reg <= pulse_cnt_next;
                pulse_lvl_reg <= pulse_lvl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

[hw/rtl/crm_checker.sv]
// ----------------------------------------------------------------------------
// crm_checker
// Port-level checks on the camera readout monitor, bound to the top level.
// ----------------------------------------------------------------------------
module crm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input crm_pkg::result_t result
);
    import crm_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // no result appears without a transfer on the item side
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_valid && item_ready) && !result_valid |=> !result_valid)
        else $error("result without item transfer");

    // event code is zero when no event is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.event_valid |-> result.event_code == EV_IDLE)
        else $error("event code set without event");

    // a stop notice always comes with the idle event
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stop_flag |->
            result.event_valid && result.event_code == EV_IDLE)
        else $error("stop notice without idle event");

    // a completing stop leaves the monitor idle or in stop
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stop_flag |->
            result.monitor_state == MS_IDLE || result.monitor_state == MS_STOP)
        else $error("stop notice in wrong monitor state");

endmodule

bind camera_readout_monitor_top crm_checker u_crm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the camera readout monitor with directed and random request streams
// under random stalls on both channels. An item-by-item status predictor
// tracks mode, debounce countdown and trigger pulse, and every result transfer
// is checked field by field. The register port is checked by readback.
// ----------------------------------------------------------------------------
module testbench;

    import crm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_t               item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // register shadow
    logic [15:0] cfg_debounce = DEBOUNCE_RST;
    logic [15:0] cfg_startup  = STARTUP_RST;
    logic [15:0] cfg_readout  = READOUT_RST;
    logic [15:0] cfg_shutdown = SHUTDOWN_RST;
    logic [7:0]  cfg_pulse    = PULSE_RST;
    logic [15:0] cfg_suppress = SUPPRESS_RST;

    // predicted monitor state
    logic [1:0]  mon_mode = MS_IDLE;
    logic        mon_busy = 1'b0;
    logic        mon_watch = 1'b1;
    logic [15:0] mon_delay = '0;
    logic        mon_delay_run = 1'b0;
    logic [7:0]  mon_pulse_cnt = '0;
    logic        mon_pulse = 1'b0;

    result_t     expected_status[$];
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned sent_count = 0;
    int unsigned cycle_count = 0;
    logic        steady = 1'b0;
    logic        line_level = 1'b0;

    camera_readout_monitor_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // status predictor
    // ------------------------------------------------------------------------
    function automatic logic report_held(item_t it);
        return it.highres_mode && (it.exposure_ms < cfg_suppress);
    endfunction

    function automatic void simulate_busy(logic [15:0] ticks);
        mon_busy = 1'b1;
        mon_delay = ticks;
        mon_delay_run = 1'b1;
    endfunction

    function automatic result_t advance_monitor(item_t it);
        result_t r;
        logic    target;
        r = '0;
        case (it.func)
            FUNC_TICK:
            begin
                // pulse first, then countdown, then line sample
                if (mon_pulse)
                begin
                    mon_pulse_cnt = mon_pulse_cnt + 8'd1;
                    if (mon_pulse_cnt >= cfg_pulse || mon_pulse_cnt == 8'd0)
                    begin
                        mon_pulse = 1'b0;
                        mon_pulse_cnt = '0;
                    end
                end
                if (mon_delay_run)
                begin
                    if (mon_delay <= 16'd1)
                    begin
                        target = mon_watch ? it.camera_line : 1'b0;
                        mon_delay_run = 1'b0;
                        mon_delay = '0;
                        if (target != mon_busy)
                        begin
                            mon_busy = target;
                            case (mon_mode)
                                MS_START:
                                begin
                                    mon_mode = MS_ACQ;
                                    r.event_valid = 1'b1;
                                    r.event_code = EV_ALIGN;
                                end
                                MS_ACQ:
                                begin
                                    if (!report_held(it))
                                    begin
                                        r.event_valid = 1'b1;
                                        r.event_code = target ? EV_READOUT : EV_EXPOSING;
                                    end
                                end
                                MS_STOP:
                                begin
                                    r.stop_flag = 1'b1;
                                    r.event_valid = 1'b1;
                                    r.event_code = EV_IDLE;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        mon_delay = mon_delay - 16'd1;
                    end
                end
                if (mon_watch && it.camera_line != mon_busy)
                begin
                    // cut a running count down, never restart it upward
                    if (!mon_delay_run)
                    begin
                        mon_delay = cfg_debounce;
                        mon_delay_run = 1'b1;
                    end
                    else if (mon_delay > cfg_debounce)
                    begin
                        mon_delay = cfg_debounce;
                    end
                end
            end
            FUNC_START:
            begin
                mon_watch = it.line_watch;
                mon_mode = MS_START;
                if (!mon_watch)
                    simulate_busy(cfg_startup);
                r.event_valid = 1'b1;
                r.event_code = EV_WAITING;
            end
            FUNC_STOP:
            begin
                r.event_valid = 1'b1;
                if (!mon_busy)
                begin
                    mon_mode = MS_IDLE;
                    r.stop_flag = 1'b1;
                    r.event_code = EV_IDLE;
                end
                else
                begin
                    mon_mode = MS_STOP;
                    r.event_code = EV_WAITING;
                    if (!mon_watch)
                        simulate_busy(cfg_shutdown);
                end
            end
            default:
            begin
                // readout trigger: restart the pulse
                mon_pulse = 1'b1;
                mon_pulse_cnt = '0;
                if (!report_held(it) && !mon_watch)
                begin
                    r.event_valid = 1'b1;
                    r.event_code = EV_READOUT;
                    simulate_busy(cfg_readout);
                end
            end
        endcase
        r.trigger_out = mon_pulse;
        r.busy_status = mon_busy;
        r.monitor_state = mon_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                     result_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                expected_status.push_back(advance_monitor(item));
            if (result_valid && result_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(result), 0);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (result.trigger_out != want.trigger_out)
                        report_mismatch("trigger_out", 32'(result.trigger_out),
                                        32'(want.trigger_out));
                    if (result.event_valid != want.event_valid)
                        report_mismatch("event_valid", 32'(result.event_valid),
                                        32'(want.event_valid));
                    if (result.event_code != want.event_code)
                        report_mismatch("event_code", 32'(result.event_code),
                                        32'(want.event_code));
                    if (result.stop_flag != want.stop_flag)
                        report_mismatch("stop_flag", 32'(result.stop_flag),
                                        32'(want.stop_flag));
                    if (result.busy_status != want.busy_status)
                        report_mismatch("busy_status", 32'(result.busy_status),
                                        32'(want.busy_status));
                    if (result.monitor_state != want.monitor_state)
                        report_mismatch("monitor_state", 32'(result.monitor_state),
                                        32'(want.monitor_state));
                end
                result_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // stall the result side about one cycle in five, except in the steady phase
    always @(negedge clk)
    begin
        result_ready = steady || ($urandom_range(99) >= 20);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_item(item_t it);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 10)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        sent_count++;
    endtask

    task automatic send_fields(logic [1:0] f, logic line, logic mon, logic hires,
                               logic [15:0] expo);
        item_t it;
        it.func = f;
        it.camera_line = line;
        it.line_watch = mon;
        it.highres_mode = hires;
        it.exposure_ms = expo;
        send_item(it);
    endtask

    // drop valid and wait for every result to come back
    task automatic finish_burst();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DEBOUNCE: cfg_debounce = data[15:0];
            REG_STARTUP:  cfg_startup = data[15:0];
            REG_READOUT:  cfg_readout = data[15:0];
            REG_SHUTDOWN: cfg_shutdown = data[15:0];
            REG_PULSE:    cfg_pulse = data[7:0];
            REG_SUPPRESS: cfg_suppress = data[15:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_check(logic [2:0] idx, logic [15:0] want);
        logic [31:0] data;
        logic [15:0] mask;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        mask = (idx == REG_PULSE) ? 16'h00FF : 16'hFFFF;
        if ((data[15:0] & mask) != (want & mask))
            report_mismatch($sformatf("register %0d readback", idx), data, 32'(want));
    endtask

    task automatic program_timing(logic [15:0] deb, logic [15:0] start_t,
                                  logic [15:0] read_t, logic [15:0] shut_t,
                                  logic [7:0] pulse_t, logic [15:0] supp);
        apb_write(REG_DEBOUNCE, {16'd0, deb});
        apb_write(REG_STARTUP, {16'd0, start_t});
        apb_write(REG_READOUT, {16'd0, read_t});
        apb_write(REG_SHUTDOWN, {16'd0, shut_t});
        apb_write(REG_PULSE, {24'd0, pulse_t});
        apb_write(REG_SUPPRESS, {16'd0, supp});
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [15:0] pick_exposure();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cfg_suppress - 16'd1;
            3:       return cfg_suppress;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // camera line with slow level changes and single-tick glitches
    task automatic send_ticks(int n);
        logic glitch;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(7) == 0)
                line_level = ~line_level;
            glitch = ($urandom_range(15) == 0);
            send_fields(FUNC_TICK, line_level ^ glitch, 1'($urandom_range(1)),
                        1'($urandom_range(1)), pick_exposure());
        end
    endtask

    task automatic send_request(logic [1:0] f, logic mon);
        send_fields(f, line_level, mon, 1'($urandom_range(1)), pick_exposure());
    endtask

    task automatic run_sessions(int n);
        int unsigned target;
        target = sent_count + n;
        while (sent_count < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_fields(2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            16'($urandom_range(65535)));
            end
            else
            begin
                send_request(FUNC_START, $urandom_range(99) < 55);
                send_ticks($urandom_range(1, 30));
                repeat ($urandom_range(0, 2))
                begin
                    send_request(FUNC_TRIGGER, 1'($urandom_range(1)));
                    send_ticks($urandom_range(1, 30));
                end
                // now and then leave the session open
                if ($urandom_range(4) != 0)
                begin
                    send_request(FUNC_STOP, 1'($urandom_range(1)));
                    send_ticks($urandom_range(1, 30));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        apb_check(REG_DEBOUNCE, DEBOUNCE_RST);
        apb_check(REG_STARTUP, STARTUP_RST);
        apb_check(REG_READOUT, READOUT_RST);
        apb_check(REG_SHUTDOWN, SHUTDOWN_RST);
        apb_check(REG_PULSE, {8'd0, PULSE_RST});
        apb_check(REG_SUPPRESS, SUPPRESS_RST);
        program_timing(16'hA55A, 16'h5AA5, 16'h0001, 16'hFFFF, 8'hA5, 16'h0000);
        apb_check(REG_DEBOUNCE, 16'hA55A);
        apb_check(REG_STARTUP, 16'h5AA5);
        apb_check(REG_READOUT, 16'h0001);
        apb_check(REG_SHUTDOWN, 16'hFFFF);
        apb_check(REG_PULSE, 16'h00A5);
        apb_check(REG_SUPPRESS, 16'h0000);
        program_timing(DEBOUNCE_RST, STARTUP_RST, READOUT_RST, SHUTDOWN_RST,
                       PULSE_RST, SUPPRESS_RST);
    endtask

    task automatic test_directed_cases();
        send_fields(FUNC_TICK, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_fields(FUNC_TICK, 1'b0, 1'b1, 1'b1, 16'hFFFF);
        // stop while ready raises the stop notice
        send_fields(FUNC_STOP, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_fields(FUNC_TRIGGER, 1'b0, 1'b0, 1'b1, 16'h0000);
        send_fields(FUNC_START, 1'b0, 1'b1, 1'b0, 16'h0000);
        // line goes busy: pulse ends, debounce expires, align
        repeat (6) send_fields(FUNC_TICK, 1'b1, 1'b0, 1'b0, 16'd500);
        send_fields(FUNC_TRIGGER, 1'b1, 1'b0, 1'b0, 16'd1000);
        send_fields(FUNC_TRIGGER, 1'b1, 1'b0, 1'b0, 16'd1000);
        // line goes ready during a short high-res exposure: report held
        repeat (6) send_fields(FUNC_TICK, 1'b0, 1'b0, 1'b1, 16'd499);
        send_fields(FUNC_START, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_fields(FUNC_START, 1'b0, 1'b1, 1'b0, 16'h0000);
        // long simulated count gets cut down to the debounce length
        send_fields(FUNC_TICK, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_fields(FUNC_STOP, 1'b0, 1'b0, 1'b0, 16'h0000);
        repeat (5) send_fields(FUNC_TICK, 1'b0, 1'b0, 1'b0, 16'h1234);
        finish_burst();
    endtask

    task automatic test_random_sessions();
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: program_timing(16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 16'd0);
                1: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
                default:
                    program_timing(16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)),
                                   16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                                   8'($urandom_range(1, 8)), pick_exposure());
            endcase
            steady = (ph == 4);
            run_sessions((ph == 1) ? 60 : 100);
            finish_burst();
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_directed_cases();
        test_random_sessions();

        finish_burst();
        repeat (10) @(posedge clk);
        if (expected_status.size() != 0)
            report_mismatch("results never returned", 0, expected_status.size());
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/crm_pkg.sv
hw/rtl/camera_readout_monitor_top.sv
hw/rtl/crm_checker.sv
tb/testbench.sv
